// ----- design/rcac_pkg.sv -----
// shared types and constants for the row cache age count replacement block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcac_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int ROW_BITS_DEF = 16;
	localparam int AGE_BITS_DEF = 16;

	localparam int ROW_W     = 16;
	localparam int SLOT_W    = 4;
	localparam int SIU_W     = 5;
	localparam int ROWCNT_W  = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SETTLE
	} state_t;

	// per-cell update control
	typedef struct packed {
		logic upd;
		logic sel;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/row_cache_age_count_replacement.sv -----
// Tag and replacement controller for a fully associative row cache. A request
// is taken when start is high and busy is low; its result is registered out of
// the ACCESS state and shown for one cycle with done high, and cannot be stalled.
// Bypass and out-of-range requests go from ACCESS straight back to idle. A lookup
// that touches the cache goes on to SETTLE: after the ages change, the victim
// search ripples through the row of slot cells one cell per clock, and busy
// stays high until it reaches the last cell.
// depends on rcac_pkg and rcac_cell
`timescale 1ns / 1ps
`default_nettype none

module row_cache_age_count_replacement #(
	parameter int SLOTS    = rcac_pkg::SLOTS_DEF,
	parameter int ROW_BITS = rcac_pkg::ROW_BITS_DEF,
	parameter int AGE_BITS = rcac_pkg::AGE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [rcac_pkg::ROW_W-1:0]        row,
	output logic                              done,
	output logic                              hit,
	output logic [rcac_pkg::SLOT_W-1:0]       slot,
	output logic                              evict_valid,
	output logic [rcac_pkg::ROW_W-1:0]        evicted_row,
	output logic                              range_error,
	input  wire                               cfg_write,
	input  wire  [rcac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [rcac_pkg::CFG_W-1:0]        cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = $clog2(SLOTS + 1);
	localparam int SIU_RST = (SLOTS < 16) ? SLOTS : 16;

	rcac_pkg::state_t state_q, state_d;
	logic [IW-1:0]    cnt_q, cnt_d;
	logic [FW-1:0]    fill_q;

	logic                                bypass_q;
	logic [rcac_pkg::SIU_W-1:0]          siu_q;
	logic [rcac_pkg::ROWCNT_W-1:0]       row_count_q;
	logic [rcac_pkg::ROW_W-1:0]          row_q;

	logic                                done_q;
	logic                                hit_q;
	logic [rcac_pkg::SLOT_W-1:0]         slot_q;
	logic                                evict_q;
	logic [rcac_pkg::ROW_W-1:0]          evicted_q;
	logic                                rerr_q;

	logic [ROW_BITS-1:0]  req_tag;
	logic [SLOTS-1:0]     match;
	logic [SLOTS-1:0]     cvalid;
	logic [ROW_BITS-1:0]  ctag   [SLOTS];
	logic [AGE_BITS-1:0]  ch_age [SLOTS+1];
	logic [IW-1:0]        ch_idx [SLOTS+1];
	logic [ROW_BITS-1:0]  ch_tag [SLOTS+1];
	logic                 ch_val [SLOTS+1];
	rcac_pkg::cell_ctl_t  ctl    [SLOTS];

	logic          in_range;
	logic          hit_any;
	logic [IW-1:0] hit_idx;
	logic          can_fill;
	logic [IW-1:0] use_idx;
	logic          do_update;
	logic          evict;
	logic [rcac_pkg::SIU_W-1:0] siu_wr;

	assign req_tag = ROW_BITS'(row_q);

	// chain head: no age yet, default victim is slot 0
	assign ch_age[0] = '0;
	assign ch_idx[0] = '0;
	assign ch_tag[0] = ctag[0];
	assign ch_val[0] = cvalid[0];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign ctl[i].upd  = do_update;
		assign ctl[i].sel  = (use_idx == IW'(i));
		assign ctl[i].load = !hit_any;

		rcac_cell #(
			.ROW_BITS (ROW_BITS),
			.AGE_BITS (AGE_BITS),
			.IW       (IW),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.req_tag   (req_tag),
			.match     (match[i]),
			.valid     (cvalid[i]),
			.tag       (ctag[i]),
			.in_age    (ch_age[i]),
			.in_idx    (ch_idx[i]),
			.in_tag    (ch_tag[i]),
			.in_valid  (ch_val[i]),
			.out_age   (ch_age[i+1]),
			.out_idx   (ch_idx[i+1]),
			.out_tag   (ch_tag[i+1]),
			.out_valid (ch_val[i+1])
		);
	end

	// tags are unique among valid slots, so at most one match bit is set
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
		end
	end

	always_comb begin
		siu_wr = cfg_data[rcac_pkg::SIU_W-1:0];
		if (siu_wr == '0) begin
			siu_wr = rcac_pkg::SIU_W'(1);
		end else if (int'(siu_wr) > SLOTS) begin
			siu_wr = rcac_pkg::SIU_W'(SLOTS);
		end
	end

	always_comb begin
		in_range  = {1'b0, row_q} < row_count_q;
		hit_any   = |match;
		can_fill  = (int'(fill_q) < int'(siu_q)) && (int'(fill_q) < SLOTS);
		if (hit_any) begin
			use_idx = hit_idx;
		end else if (can_fill) begin
			use_idx = IW'(fill_q);
		end else begin
			use_idx = ch_idx[SLOTS];
		end
		evict     = !hit_any && !can_fill && ch_val[SLOTS];
		do_update = (state_q == rcac_pkg::ST_ACCESS) && !bypass_q && in_range;

		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			rcac_pkg::ST_IDLE: begin
				if (start) begin
					state_d = rcac_pkg::ST_ACCESS;
				end
			end
			rcac_pkg::ST_ACCESS: begin
				if (do_update) begin
					state_d = rcac_pkg::ST_SETTLE;
					cnt_d   = IW'(SLOTS - 1);
				end else begin
					state_d = rcac_pkg::ST_IDLE;
				end
			end
			rcac_pkg::ST_SETTLE: begin
				if (cnt_q == '0) begin
					state_d = rcac_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q - IW'(1);
				end
			end
			default: begin
				state_d = rcac_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcac_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q    <= 1'b0;
			siu_q       <= rcac_pkg::SIU_W'(SIU_RST);
			row_count_q <= rcac_pkg::ROWCNT_W'(65536);
		end else if (cfg_write) begin
			unique case (cfg_index)
				rcac_pkg::REG_BYPASS:    bypass_q    <= cfg_data[0];
				rcac_pkg::REG_SLOTS_USE: siu_q       <= siu_wr;
				rcac_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (do_update && !hit_any && can_fill) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcac_pkg::ST_IDLE && start) begin
			row_q <= row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == rcac_pkg::ST_ACCESS);
		end
	end

	// result of the transaction
	always_ff @(posedge clk) begin
		if (state_q == rcac_pkg::ST_ACCESS) begin
			hit_q     <= 1'b0;
			slot_q    <= '0;
			evict_q   <= 1'b0;
			evicted_q <= '0;
			rerr_q    <= 1'b0;
			if (!bypass_q) begin
				if (!in_range) begin
					rerr_q <= 1'b1;
				end else begin
					hit_q   <= hit_any;
					slot_q  <= rcac_pkg::SLOT_W'(use_idx);
					evict_q <= evict;
					if (evict) begin
						evicted_q <= rcac_pkg::ROW_W'(ch_tag[SLOTS]);
					end
				end
			end
		end
	end

	assign busy        = (state_q != rcac_pkg::ST_IDLE);
	assign done        = done_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign evict_valid = evict_q;
	assign evicted_row = evicted_q;
	assign range_error = rerr_q;

endmodule

`default_nettype wire

// ----- design/rcac_cell.sv -----
// one cache slot cell: tag, valid, age, and one stage of the victim chain
// depends on rcac_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcac_cell #(
	parameter int ROW_BITS = rcac_pkg::ROW_BITS_DEF,
	parameter int AGE_BITS = rcac_pkg::AGE_BITS_DEF,
	parameter int IW       = 4,
	parameter int IDX      = 0
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  rcac_pkg::cell_ctl_t      ctl,
	input  wire  [ROW_BITS-1:0]      req_tag,
	output logic                     match,
	output logic                     valid,
	output logic [ROW_BITS-1:0]      tag,
	input  wire  [AGE_BITS-1:0]      in_age,
	input  wire  [IW-1:0]            in_idx,
	input  wire  [ROW_BITS-1:0]      in_tag,
	input  wire                      in_valid,
	output logic [AGE_BITS-1:0]      out_age,
	output logic [IW-1:0]            out_idx,
	output logic [ROW_BITS-1:0]      out_tag,
	output logic                     out_valid
);

	logic [ROW_BITS-1:0] tag_q;
	logic                valid_q;
	logic [AGE_BITS-1:0] age_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [IW-1:0]       best_idx_q;
	logic [ROW_BITS-1:0] best_tag_q;
	logic                best_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (ctl.upd) begin
			if (ctl.sel) begin
				age_q   <= '0;
				valid_q <= 1'b1;
			end else if (valid_q && (age_q != {AGE_BITS{1'b1}})) begin
				age_q <= age_q + AGE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && ctl.sel && ctl.load) begin
			tag_q <= req_tag;
		end
	end

	// running maximum, first slot wins on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_age_q   <= '0;
			best_idx_q   <= '0;
			best_tag_q   <= '0;
			best_valid_q <= 1'b0;
		end else if (age_q > in_age) begin
			best_age_q   <= age_q;
			best_idx_q   <= IW'(IDX);
			best_tag_q   <= tag_q;
			best_valid_q <= 1'b1;
		end else begin
			best_age_q   <= in_age;
			best_idx_q   <= in_idx;
			best_tag_q   <= in_tag;
			best_valid_q <= in_valid;
		end
	end

	assign match     = valid_q && (tag_q == req_tag);
	assign valid     = valid_q;
	assign tag       = tag_q;
	assign out_age   = best_age_q;
	assign out_idx   = best_idx_q;
	assign out_tag   = best_tag_q;
	assign out_valid = best_valid_q;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for row_cache_age_count_replacement: directed and random row requests,
// each transaction checked against a built-in model of the tags, ages and victim
// depends on rcac_pkg and row_cache_age_count_replacement
`timescale 1ns / 1ps

module tb_top;

	localparam int NSLOT     = rcac_pkg::SLOTS_DEF;
	localparam int AGE_W     = rcac_pkg::AGE_BITS_DEF;
	localparam int ROW_W     = rcac_pkg::ROW_W;
	localparam int SLOT_W    = rcac_pkg::SLOT_W;
	localparam int SIU_W     = rcac_pkg::SIU_W;
	localparam int ROWCNT_W  = rcac_pkg::ROWCNT_W;
	localparam int CFG_IDX_W = rcac_pkg::CFG_IDX_W;
	localparam int CFG_W     = rcac_pkg::CFG_W;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ROWS = 238;
	localparam int MAX_ROW_COUNT = 65536;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evict_valid;
		logic [ROW_W-1:0]  evicted_row;
		logic              range_error;
	} cache_result_t;

	class cache_scoreboard;
		logic [ROW_W-1:0] tag [NSLOT];
		bit               valid [NSLOT];
		logic [AGE_W-1:0] age [NSLOT];
		int               fill_count;
		int               victim;
		bit               bypass;
		int               slots_use;
		int               row_limit;
		cache_result_t    expected_q [$];
		int               mismatches;

		function new();
			foreach (valid[s]) begin
				valid[s] = 1'b0;
				age[s] = '0;
				tag[s] = '0;
			end
			fill_count = 0;
			victim = 0;
			bypass = 1'b0;
			slots_use = NSLOT;
			row_limit = MAX_ROW_COUNT;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			int v;
			case (idx)
				rcac_pkg::REG_BYPASS: begin
					bypass = val[0];
				end
				rcac_pkg::REG_SLOTS_USE: begin
					v = int'(val[SIU_W-1:0]);
					if (v == 0) v = 1;
					if (v > NSLOT) v = NSLOT;
					slots_use = v;
				end
				rcac_pkg::REG_ROW_COUNT: begin
					row_limit = int'(val[ROWCNT_W-1:0]);
				end
				default: begin
				end
			endcase
		endfunction

		// lookup, fill or replace, then age the other valid slots and pick the victim
		function void note_request(logic [ROW_W-1:0] r);
			cache_result_t e;
			int used;
			int best;
			int s;
			e = '0;
			used = -1;
			if (bypass) begin
				expected_q.push_back(e);
				return;
			end
			if (int'(r) >= row_limit) begin
				e.range_error = 1'b1;
				expected_q.push_back(e);
				return;
			end
			for (s = 0; s < NSLOT; s++)
				if (used < 0 && valid[s] && tag[s] == r) used = s;
			if (used >= 0) begin
				e.hit = 1'b1;
			end else begin
				if (fill_count < slots_use) begin
					used = fill_count;
					fill_count++;
				end else begin
					used = victim;
					if (valid[used]) begin
						e.evict_valid = 1'b1;
						e.evicted_row = tag[used];
					end
				end
				tag[used] = r;
				valid[used] = 1'b1;
			end
			age[used] = '0;
			best = 0;
			victim = 0;
			for (s = 0; s < NSLOT; s++) begin
				if (s != used && valid[s]) begin
					if (age[s] != '1) age[s]++;
					if (int'(age[s]) > best) begin
						best = int'(age[s]);
						victim = s;
					end
				end
			end
			e.slot = used[SLOT_W-1:0];
			expected_q.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (mismatches < 50)
				$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_result(cache_result_t got);
			cache_result_t want;
			if (expected_q.size() == 0) begin
				report("transaction with nothing pending", got[31:0], 32'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
			if (got.slot !== want.slot) report("slot", 32'(got.slot), 32'(want.slot));
			if (got.evict_valid !== want.evict_valid)
				report("evict_valid", 32'(got.evict_valid), 32'(want.evict_valid));
			if (got.evicted_row !== want.evicted_row)
				report("evicted_row", 32'(got.evicted_row), 32'(want.evicted_row));
			if (got.range_error !== want.range_error)
				report("range_error", 32'(got.range_error), 32'(want.range_error));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [ROW_W-1:0]     row = '0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 busy;
	logic                 done;
	logic                 hit;
	logic [SLOT_W-1:0]    slot;
	logic                 evict_valid;
	logic [ROW_W-1:0]     evicted_row;
	logic                 range_error;
	int                   stall_cycles = 0;

	cache_scoreboard sb = new();

	row_cache_age_count_replacement u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.row         (row),
		.done        (done),
		.hit         (hit),
		.slot        (slot),
		.evict_valid (evict_valid),
		.evicted_row (evicted_row),
		.range_error (range_error),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result({hit, slot, evict_valid, evicted_row, range_error});
			if (start && !busy) sb.note_request(row);
			if (done || (start && !busy)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL row_cache_age_count_replacement");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task send_row(logic [ROW_W-1:0] r);
		row <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// drain all results and let the victim search finish before touching registers
	task wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0 || busy) @(posedge clk);
		repeat (NSLOT + 4) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// mostly a working set a little larger than the enabled slots, some noise
	function automatic logic [ROW_W-1:0] pick_row(int base, int span, int limit);
		int sel;
		int r;
		sel = $urandom_range(0, 99);
		if (sel < 80) r = base + $urandom_range(0, span - 1);
		else if (sel < 90) r = $urandom_range(0, MAX_ROW_COUNT - 1);
		else if (sel < 95) r = limit - 1;
		else r = limit;
		return r[ROW_W-1:0];
	endfunction

	task run_phase(bit byp, int siu_val, int rc_val, int idle_pct, int n);
		int span;
		int base;
		int i;
		wait_idle();
		write_reg(rcac_pkg::REG_BYPASS, CFG_W'(byp));
		write_reg(rcac_pkg::REG_SLOTS_USE, CFG_W'(siu_val));
		write_reg(rcac_pkg::REG_ROW_COUNT, CFG_W'(rc_val));
		span = sb.slots_use + $urandom_range(1, 4);
		if (rc_val > span) base = $urandom_range(0, rc_val - span);
		else base = 0;
		for (i = 0; i < n; i++) begin
			send_row(pick_row(base, span, rc_val));
			if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 24));
		end
	endtask

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all slots, hit, then evict
		send_row(16'h0000);
		send_row(16'hFFFF);
		send_row(16'h0000);
		send_row(16'h5555);
		send_row(16'hAAAA);
		for (i = 1; i <= 12; i++) send_row(i[ROW_W-1:0]);
		send_row(16'd100);
		send_row(16'h0000);

		// bypass, plus a write to an unused index
		wait_idle();
		write_reg(rcac_pkg::REG_BYPASS, CFG_W'(1));
		write_reg(REG_UNUSED, '1);
		send_row(16'd7);
		send_row(16'hFFFF);

		// no legal rows at all
		wait_idle();
		write_reg(rcac_pkg::REG_BYPASS, CFG_W'(0));
		write_reg(rcac_pkg::REG_ROW_COUNT, CFG_W'(0));
		send_row(16'h0000);

		// range boundary and slot count dropped below the filled slots
		wait_idle();
		write_reg(rcac_pkg::REG_ROW_COUNT, CFG_W'(1000));
		write_reg(rcac_pkg::REG_SLOTS_USE, CFG_W'(0));
		send_row(16'd999);
		send_row(16'd1000);
		send_row(16'hFFFF);
		send_row(16'd500);

		run_phase(1'b0, 16, MAX_ROW_COUNT, 0, PHASE_ROWS);
		run_phase(1'b0, 1, MAX_ROW_COUNT, 45, PHASE_ROWS);
		run_phase(1'b0, 31, $urandom_range(20, MAX_ROW_COUNT), 35, PHASE_ROWS);
		run_phase(1'b0, $urandom_range(2, 15), MAX_ROW_COUNT, 0, PHASE_ROWS);
		run_phase(1'b1, 16, MAX_ROW_COUNT, 45, PHASE_ROWS);
		run_phase(1'b0, $urandom_range(2, 15), 1, 35, PHASE_ROWS);
		run_phase(1'b0, 16, MAX_ROW_COUNT - 1, 0, PHASE_ROWS);
		run_phase(1'b0, $urandom_range(0, 31), $urandom_range(1, MAX_ROW_COUNT), 45, PHASE_ROWS);

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASS row_cache_age_count_replacement");
		end else begin
			$display("FAIL row_cache_age_count_replacement");
		end
		$finish;
	end

endmodule
